// ===== src/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and codes of the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package prq_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT   = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_REQUEUE  = 2'd2,
		CMD_DISPATCH = 2'd3
	} cmd_e_t;

	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;

	localparam logic [1:0] RC_OK      = 2'd0;
	localparam logic [1:0] RC_BAD_PRI = 2'd1;
	localparam logic [1:0] RC_NO_TASK = 2'd2;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_RD_T, S_RD_L,
		S_UL_P, S_UL_PW, S_UL_N, S_UL_NW, S_UL_FIN,
		S_AP_RD, S_AP_L, S_AP_PW, S_AP_TW,
		S_DS_DEM, S_DS_LVL, S_DS_TSK, S_DS_FAIL, S_FIN
	} seq_state_t;

	// finished command handed to the output stage
	typedef struct packed {
		logic       valid;
		logic [4:0] sel;
		logic [1:0] code;
	} fin_t;

endpackage

// ===== src/priority_ready_queue_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_core
// Fixed-priority FIFO ready queues with insert, remove, requeue and dispatch.
// ----------------------------------------------------------------------------
// One command is worked at a time. After reset the task and level tables are
// swept clear before the first transfer is taken. Insert, remove and requeue
// run read-modify-write steps on the task and level RAMs, each with one write
// and one read port; an insert with a bad priority, or any command but dispatch
// with a task index out of range, goes straight to the finish state. The
// dispatch walk reads one list link or one level head per cycle. A finished
// result sits in an output register, so the next command is taken while it
// waits.
module priority_ready_queue_scheduler_core #(
	parameter int NUM_TASKS  = 32,
	parameter int NUM_LEVELS = 16,
	parameter int NUM_CPUS   = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [4:0] task_index,
	input  logic [4:0] priority_req,
	input  logic [1:0] new_status,
	input  logic       cpu_select,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] selected_task,
	output logic [1:0] result_code
);
	import prq_pkg::*;

	fin_t fin;
	logic fin_ack, idle, out_valid_q;
	logic [4:0] sel_q;
	logic [1:0] code_q;

	prq_ctrl #(
		.NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS), .NUM_CPUS(NUM_CPUS)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(in_valid && in_ready),
		.command(command), .task_index(task_index), .priority_req(priority_req),
		.new_status(new_status), .cpu_select(cpu_select),
		.idle(idle), .fin(fin), .fin_ack(fin_ack)
	);

	assign in_ready = idle;
	assign fin_ack  = fin.valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_ack) begin
			sel_q  <= fin.sel;
			code_q <= fin.code;
		end
	end

	assign out_valid     = out_valid_q;
	assign selected_task = sel_q;
	assign result_code   = code_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while another is in progress");

	a_sel_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_code != RC_OK |-> selected_task == 5'd0)
		else $error("task reported with an error code");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fin_ack |-> !out_valid_q || out_ready)
		else $error("pending result overwritten");

endmodule

// ===== src/prq_ram.sv =====
// ----------------------------------------------------------------------------
// prq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/prq_ctrl.sv =====
// ----------------------------------------------------------------------------
// prq_ctrl
// Command sequencer: task and level tables in RAM, read-modify-write of the
// linked lists, and the dispatch walk over the priority levels.
// ----------------------------------------------------------------------------
module prq_ctrl #(
	parameter int NUM_TASKS  = 32,
	parameter int NUM_LEVELS = 16,
	parameter int NUM_CPUS   = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    command,
	input  logic [4:0]    task_index,
	input  logic [4:0]    priority_req,
	input  logic [1:0]    new_status,
	input  logic          cpu_select,
	output logic          idle,
	output prq_pkg::fin_t fin,
	input  logic          fin_ack
);
	import prq_pkg::*;

	localparam int TW  = $clog2(NUM_TASKS);
	localparam int KW  = $clog2(NUM_TASKS + 1);
	localparam int LW  = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS) : 1;
	localparam int CW  = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
	localparam int M   = NUM_TASKS > NUM_LEVELS ? NUM_TASKS : NUM_LEVELS;
	localparam int CLW = $clog2(M);
	localparam logic [KW-1:0] NIL = KW'(NUM_TASKS);

	typedef struct packed {
		logic [1:0]    status;
		logic [LW-1:0] level;
		logic          aff;
		logic [KW-1:0] nxt;
		logic [KW-1:0] prv;
	} tent_t;

	typedef struct packed {
		logic [KW-1:0] head;
		logic [KW-1:0] tail;
	} lent_t;

	seq_state_t    state_q, state_d;
	cmd_e_t        cmd_q;
	logic [TW-1:0] tid_q, cur_q, old_q;
	logic [1:0]    st_q;
	logic          cpu_q;
	logic [LW-1:0] tgt_q, lvl_q;
	tent_t         t_q, old_ent_q;
	lent_t         l_q;
	logic          demoted_q;
	logic [1:0]    code_q;
	logic [4:0]    sel_q;
	logic [CLW-1:0] clr_q;
	logic [TW-1:0] run_q [NUM_CPUS];

	logic          t_we, l_we;
	logic [TW-1:0] t_waddr, t_raddr;
	logic [LW-1:0] l_waddr, l_raddr;
	tent_t         t_wdata, t_rd;
	lent_t         l_wdata, l_rd;
	logic [CW-1:0] cpu_i;
	logic          queued, lvl_last, hit;

	prq_ram #(.WIDTH($bits(tent_t)), .DEPTH(NUM_TASKS)) u_task_ram (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rd)
	);

	prq_ram #(.WIDTH($bits(lent_t)), .DEPTH(NUM_LEVELS)) u_level_ram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rd)
	);

	assign cpu_i    = CW'(cpu_select);
	assign queued   = (t_q.prv != NIL) || (l_rd.head == KW'(tid_q));
	assign lvl_last = lvl_q == LW'(NUM_LEVELS - 1);
	assign hit      = (t_rd.status == ST_READY) && (t_rd.aff == cpu_q);
	assign idle     = state_q == S_IDLE;
	assign fin      = '{valid: state_q == S_FIN, sel: sel_q, code: code_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				run_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_DS_TSK && hit) begin
				run_q[CW'(cpu_q)] <= cur_q;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q     <= cmd_e_t'(command);
				tid_q     <= TW'(task_index);
				st_q      <= new_status;
				cpu_q     <= cpu_select;
				tgt_q     <= LW'(32'(priority_req) - 1);
				old_q     <= run_q[cpu_i];
				demoted_q <= 1'b0;
				sel_q     <= '0;
				if (command == CMD_DISPATCH) begin
					code_q <= 32'(cpu_select) < NUM_CPUS ? RC_OK : RC_NO_TASK;
				end else if (command == CMD_INSERT && 32'(task_index) < NUM_TASKS &&
						(priority_req == 5'd0 || 32'(priority_req) > NUM_LEVELS)) begin
					code_q <= RC_BAD_PRI;
				end else begin
					code_q <= RC_OK;
				end
			end
			S_RD_T: t_q <= t_rd;
			S_RD_L: begin
				l_q <= l_rd;
				if (cmd_q != CMD_REMOVE) begin
					t_q.status <= st_q;
				end
				if (cmd_q == CMD_INSERT) begin
					t_q.aff <= cpu_q;
				end
				if (cmd_q == CMD_REQUEUE) begin
					tgt_q <= t_q.level;
				end
			end
			S_UL_P: begin
				if (t_q.prv == NIL) begin
					l_q.head <= t_q.nxt;
				end
			end
			S_UL_N: begin
				if (t_q.nxt == NIL) begin
					l_q.tail <= t_q.prv;
				end
			end
			S_UL_FIN: begin
				t_q.prv <= NIL;
				t_q.nxt <= NIL;
			end
			S_AP_L: begin
				t_q.level <= tgt_q;
				t_q.prv   <= l_rd.tail;
				t_q.nxt   <= NIL;
			end
			S_DS_DEM: begin
				old_ent_q <= t_rd;
				demoted_q <= (old_q != '0) && (t_rd.status == ST_RUNNING);
				lvl_q     <= '0;
			end
			S_DS_LVL: begin
				if (l_rd.head == NIL) begin
					lvl_q <= lvl_q + 1'b1;
				end else begin
					cur_q <= l_rd.head[TW-1:0];
				end
			end
			S_DS_TSK: begin
				if (hit) begin
					sel_q <= 5'(cur_q);
				end else if (t_rd.nxt == NIL) begin
					lvl_q <= lvl_q + 1'b1;
				end else begin
					cur_q <= t_rd.nxt[TW-1:0];
				end
			end
			S_DS_FAIL: code_q <= RC_NO_TASK;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		t_we    = 1'b0;
		t_waddr = tid_q;
		t_wdata = t_q;
		t_raddr = tid_q;
		l_we    = 1'b0;
		l_waddr = t_q.level;
		l_wdata = l_q;
		l_raddr = t_q.level;
		unique case (state_q)
			S_CLR: begin
				t_we    = 32'(clr_q) < NUM_TASKS;
				t_waddr = clr_q[TW-1:0];
				t_wdata = '{status: '0, level: '0, aff: 1'b0, nxt: NIL, prv: NIL};
				l_we    = 32'(clr_q) < NUM_LEVELS;
				l_waddr = clr_q[LW-1:0];
				l_wdata = '{head: NIL, tail: NIL};
				if (clr_q == CLW'(M - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				t_raddr = TW'(task_index);
				if (start) begin
					if (command == CMD_DISPATCH) begin
						t_raddr = run_q[cpu_i];
						state_d = 32'(cpu_select) < NUM_CPUS ? S_DS_DEM : S_FIN;
					end else if (32'(task_index) >= NUM_TASKS) begin
						state_d = S_FIN;
					end else if (command == CMD_INSERT && (priority_req == 5'd0 ||
							32'(priority_req) > NUM_LEVELS)) begin
						state_d = S_FIN;
					end else begin
						state_d = S_RD_T;
					end
				end
			end
			S_RD_T: begin
				l_raddr = t_rd.level;
				state_d = S_RD_L;
			end
			S_RD_L: begin
				if (queued) begin
					state_d = S_UL_P;
				end else begin
					case (cmd_q)
						CMD_REMOVE: state_d = S_FIN;
						CMD_INSERT: state_d = S_AP_RD;
						default:    state_d = S_AP_TW;
					endcase
				end
			end
			S_UL_P: begin
				t_raddr = t_q.prv[TW-1:0];
				state_d = t_q.prv == NIL ? S_UL_N : S_UL_PW;
			end
			S_UL_PW: begin
				t_we        = 1'b1;
				t_waddr     = t_q.prv[TW-1:0];
				t_wdata     = t_rd;
				t_wdata.nxt = t_q.nxt;
				state_d     = S_UL_N;
			end
			S_UL_N: begin
				t_raddr = t_q.nxt[TW-1:0];
				state_d = t_q.nxt == NIL ? S_UL_FIN : S_UL_NW;
			end
			S_UL_NW: begin
				t_we        = 1'b1;
				t_waddr     = t_q.nxt[TW-1:0];
				t_wdata     = t_rd;
				t_wdata.prv = t_q.prv;
				state_d     = S_UL_FIN;
			end
			S_UL_FIN: begin
				l_we = 1'b1;
				if (cmd_q == CMD_REMOVE) begin
					t_we        = 1'b1;
					t_wdata.prv = NIL;
					t_wdata.nxt = NIL;
					state_d     = S_FIN;
				end else begin
					state_d = S_AP_RD;
				end
			end
			S_AP_RD: begin
				l_raddr = tgt_q;
				state_d = S_AP_L;
			end
			S_AP_L: begin
				l_we         = 1'b1;
				l_waddr      = tgt_q;
				l_wdata.head = l_rd.tail == NIL ? KW'(tid_q) : l_rd.head;
				l_wdata.tail = KW'(tid_q);
				t_raddr      = l_rd.tail[TW-1:0];
				state_d      = l_rd.tail == NIL ? S_AP_TW : S_AP_PW;
			end
			S_AP_PW: begin
				t_we        = 1'b1;
				t_waddr     = t_q.prv[TW-1:0];
				t_wdata     = t_rd;
				t_wdata.nxt = KW'(tid_q);
				state_d     = S_AP_TW;
			end
			S_AP_TW: begin
				t_we    = 1'b1;
				state_d = S_FIN;
			end
			S_DS_DEM: begin
				// running task of this cpu, if not task 0, drops back to ready
				t_we           = (old_q != '0) && (t_rd.status == ST_RUNNING);
				t_waddr        = old_q;
				t_wdata        = t_rd;
				t_wdata.status = ST_READY;
				l_raddr        = '0;
				state_d        = S_DS_LVL;
			end
			S_DS_LVL: begin
				l_raddr = lvl_q + 1'b1;
				t_raddr = l_rd.head[TW-1:0];
				if (l_rd.head != NIL) begin
					state_d = S_DS_TSK;
				end else if (lvl_last) begin
					state_d = S_DS_FAIL;
				end
			end
			S_DS_TSK: begin
				l_raddr = lvl_q + 1'b1;
				t_raddr = t_rd.nxt[TW-1:0];
				t_waddr = cur_q;
				t_wdata = t_rd;
				t_wdata.status = ST_RUNNING;
				if (hit) begin
					t_we    = 1'b1;
					state_d = S_FIN;
				end else if (t_rd.nxt == NIL) begin
					state_d = lvl_last ? S_DS_FAIL : S_DS_LVL;
				end
			end
			S_DS_FAIL: begin
				// nothing found, old task resumes
				t_we    = demoted_q;
				t_waddr = old_q;
				t_wdata = old_ent_q;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (fin_ack) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
